// ===== rtl/core/lnb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LIF backward package
// Shared types, register codes and arithmetic helpers of the LIF neuron
// backward pipeline.
// ----------------------------------------------------------------------------
package lnb_pkg;

  localparam int unsigned IDX_W      = 10;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned ALPHA_W    = 31;
  localparam int unsigned RTAU_W     = 25;
  localparam int unsigned QUOT_W     = 30;
  localparam int unsigned CFG_ADDR_W = 3;

  // pi/2 in Q1.30.
  localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;
  // Reset alpha times pi/2, shifted back to Q(FRAC_BITS).
  localparam logic [31:0] PSCALE_RST = 32'd52707178;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_THRESHOLD    = 3'd0,
    CFG_RESET_LEVEL  = 3'd1,
    CFG_ALPHA        = 3'd2,
    CFG_RTAU         = 3'd3,
    CFG_DECAY_INPUT  = 3'd4,
    CFG_HARD_RESET   = 3'd5,
    CFG_DETACH_RESET = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] threshold;
    logic signed [DATA_W-1:0] reset_level;
    logic [ALPHA_W-1:0]       alpha;
    logic [RTAU_W-1:0]        rtau;
    logic                     decay_input;
    logic                     hard_reset;
    logic                     detach_reset;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] membrane;
    logic                     spike;
    logic signed [DATA_W-1:0] spike_grad;
    logic signed [DATA_W-1:0] fvg;
    logic                     first;
    logic                     last;
  } item_t;

  // Width of the scaled distance x that still matters for the surrogate.
  function automatic int unsigned x_width(input int unsigned fb);
    return (fb + 16 < 65 - fb) ? fb + 16 : 65 - fb;
  endfunction

  // Width of the surrogate denominator; its all-ones value forces sg to zero.
  function automatic int unsigned den_width(input int unsigned fb);
    int unsigned xw;
    int unsigned sw;
    xw = x_width(fb);
    sw = 2 * xw - fb;
    return ((sw > fb + 31) ? sw : fb + 31) + 1;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] max_v;
    logic signed [65:0] min_v;
    max_v = 66'sd2147483647;
    min_v = -66'sd2147483648;
    if (v > max_v) begin
      return 32'sh7FFF_FFFF;
    end else if (v < min_v) begin
      return 32'sh8000_0000;
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [65:0] apply_sign(input logic [63:0] mag, input logic neg);
    logic signed [65:0] m;
    m = $signed({2'b00, mag});
    return neg ? -m : m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lnb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LIF backward front end
// Four stages that form the surrogate denominator 1 + (pi/2*a*(h-thr))^2.
// ----------------------------------------------------------------------------
module lnb_front #(
  parameter int unsigned FRAC_BITS = 24,
  parameter int unsigned DEN_W     = 57
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire lnb_pkg::cfg_t cfg_i,
  input  wire logic          valid_i,
  input  wire lnb_pkg::item_t item_i,
  output logic               valid_o,
  output lnb_pkg::item_t     item_o,
  output logic [DEN_W-1:0]   den_o
);
  import lnb_pkg::*;

  localparam int unsigned XW   = x_width(FRAC_BITS);
  localparam int unsigned XF   = 65 - FRAC_BITS;
  localparam int unsigned XL   = XW / 2;
  localparam int unsigned XH   = XW - XL;
  localparam int unsigned LL_W = 2 * XL;
  localparam int unsigned LH_W = XL + XH;
  localparam int unsigned HH_W = 2 * XH;
  localparam int unsigned SQ_W = 2 * XW;
  localparam int unsigned SS_W = 2 * XW - FRAC_BITS;

  logic [31:0] pscale_q;
  logic [61:0] ps_prod;

  logic [3:0] vld_q;
  item_t      it1_q, it2_q, it3_q, it4_q;

  logic signed [32:0] diff;
  logic [32:0]        mag1_d, mag1_q;
  logic [64:0]        prod2;
  logic [XF-1:0]      xfull;
  logic               big2_d, big2_q, big3_q;
  logic [XW-1:0]      x_q;
  logic [XL-1:0]      x_lo;
  logic [XH-1:0]      x_hi;
  logic [LL_W-1:0]    pll_q;
  logic [LH_W-1:0]    plh_q;
  logic [HH_W-1:0]    phh_q;
  logic [SQ_W-1:0]    sq;
  logic [SS_W-1:0]    sq_shift;
  logic [DEN_W-1:0]   den_d, den_q;

  // The scale factor follows alpha through a register; it is used from stage two on.
  assign ps_prod = 62'(cfg_i.alpha) * 62'(HALFPI_Q30);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pscale_q <= PSCALE_RST;
    end else begin
      pscale_q <= ps_prod[61:30];
    end
  end

  always_comb begin
    diff   = $signed({item_i.membrane[31], item_i.membrane})
           - $signed({cfg_i.threshold[31], cfg_i.threshold});
    mag1_d = diff[32] ? 33'(-diff) : 33'(diff);
  end

  always_comb begin
    prod2  = 65'(mag1_q) * 65'(pscale_q);
    xfull  = prod2[64:FRAC_BITS];
    big2_d = |(xfull >> XW);
  end

  assign x_lo = x_q[XL-1:0];
  assign x_hi = x_q[XW-1:XL];

  always_comb begin
    sq = (SQ_W'(phh_q) << (2 * XL)) + (SQ_W'(plh_q) << (XL + 1)) + SQ_W'(pll_q);
    sq_shift = sq[SQ_W-1:FRAC_BITS];
    den_d = big3_q ? '1 : DEN_W'(sq_shift) + (DEN_W'(1) << FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it1_q  <= item_i;
      mag1_q <= mag1_d;
      it2_q  <= it1_q;
      x_q    <= xfull[XW-1:0];
      big2_q <= big2_d;
      it3_q  <= it2_q;
      big3_q <= big2_q;
      pll_q  <= LL_W'(x_lo) * LL_W'(x_lo);
      plh_q  <= LH_W'(x_lo) * LH_W'(x_hi);
      phh_q  <= HH_W'(x_hi) * HH_W'(x_hi);
      it4_q  <= it3_q;
      den_q  <= den_d;
    end
  end

  assign valid_o = vld_q[3];
  assign item_o  = it4_q;
  assign den_o   = den_q;

endmodule
`default_nettype wire

// ===== rtl/core/lnb_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LIF backward divider
// Pipelined restoring divider, one quotient bit per stage, for
// sg = (alpha / 2) / den in Q(FRAC_BITS).
// ----------------------------------------------------------------------------
module lnb_divider #(
  parameter int unsigned FRAC_BITS = 24,
  parameter int unsigned DEN_W     = 57
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire lnb_pkg::cfg_t              cfg_i,
  input  wire logic                       valid_i,
  input  wire lnb_pkg::item_t             item_i,
  input  wire logic [DEN_W-1:0]           den_i,
  output logic                            valid_o,
  output lnb_pkg::item_t                  item_o,
  output logic [lnb_pkg::QUOT_W-1:0]      sg_o
);
  import lnb_pkg::*;

  localparam int unsigned NUM_W = FRAC_BITS + 30;
  localparam int unsigned CMP_W = DEN_W + QUOT_W;

  logic [NUM_W-1:0]  rem_q [QUOT_W];
  logic [DEN_W-1:0]  den_q [QUOT_W];
  logic [QUOT_W-1:0] quo_q [QUOT_W];
  item_t             item_q [QUOT_W];
  logic              vld_q [QUOT_W];

  for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
    localparam int unsigned BIT = QUOT_W - 1 - s;

    logic [NUM_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [QUOT_W-1:0] quo_in;
    item_t             item_in;
    logic              vld_in;
    logic [CMP_W-1:0]  trial;
    logic              ge;

    if (s == 0) begin : g_head
      assign rem_in  = NUM_W'(cfg_i.alpha) << (FRAC_BITS - 1);
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign item_in = item_i;
      assign vld_in  = valid_i;
    end else begin : g_body
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign item_in = item_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    assign trial = CMP_W'(den_in) << BIT;
    assign ge    = CMP_W'(rem_in) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? rem_in - trial[NUM_W-1:0] : rem_in;
        quo_q[s]  <= quo_in | (ge ? (QUOT_W'(1) << BIT) : '0);
        den_q[s]  <= den_in;
        item_q[s] <= item_in;
      end
    end
  end

  assign valid_o = vld_q[QUOT_W-1];
  assign item_o  = item_q[QUOT_W-1];
  assign sg_o    = quo_q[QUOT_W-1];

endmodule
`default_nettype wire

// ===== rtl/core/lnb_backend.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LIF backward carry stage
// Reset factor, carry recurrence through the per-neuron carry memory,
// output scaling and the output register.
// ----------------------------------------------------------------------------
module lnb_backend #(
  parameter int unsigned NEURONS   = 1024,
  parameter int unsigned FRAC_BITS = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lnb_pkg::cfg_t         cfg_i,
  input  wire logic                  valid_i,
  input  wire lnb_pkg::item_t        item_i,
  input  wire logic [lnb_pkg::QUOT_W-1:0] sg_i,
  output logic                       front_en_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [63:0]                out_data_o,
  output logic                       out_last_o
);
  import lnb_pkg::*;

  localparam int unsigned AW      = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int unsigned RECIP   = ((1 << 20) + NEURONS - 1) / NEURONS;
  localparam int unsigned PF_W    = 63 - FRAC_BITS;
  localparam int unsigned PG_W    = 62 - FRAC_BITS;
  localparam int unsigned GT_W    = 63 - FRAC_BITS;
  localparam int unsigned PC_W    = 63 - FRAC_BITS;
  localparam int unsigned PO_W    = 63 - FRAC_BITS;

  logic adv, hazard;

  // Stage P1: surrogate products and index reduction.
  logic [AW-1:0]      idx_red;
  logic signed [32:0] a_op;
  logic               a_neg;
  logic [32:0]        a_mag;
  logic [62:0]        pf_full;
  logic signed [32:0] gs_x;
  logic [31:0]        g_mag;
  logic [61:0]        pg_full;

  logic               p1_valid_q, p1_spike_q, p1_first_q, p1_last_q;
  logic [AW-1:0]      p1_idx_q;
  logic signed [31:0] p1_fvg_q;
  logic [PF_W-1:0]    pf_mag_q;
  logic               pf_neg_q;
  logic [PG_W-1:0]    pg_mag_q;
  logic               pg_neg_q;

  // Stage B0: reset factor and gradient term.
  logic signed [65:0] term, base, gt_full;
  logic signed [31:0] f_d;

  logic               b0_valid_q, b0_first_q, b0_last_q;
  logic [AW-1:0]      b0_idx_q;
  logic signed [31:0] b0_f_q, b0_fvg_q;
  logic signed [GT_W-1:0] b0_gt_q;

  // Stage B1: carry memory read.
  logic [31:0]        mem_q [NEURONS];
  logic [31:0]        rd_q;
  logic               b1_valid_q, b1_first_q, b1_last_q;
  logic [AW-1:0]      b1_idx_q;
  logic signed [31:0] b1_f_q, b1_fvg_q;
  logic signed [GT_W-1:0] b1_gt_q;
  logic signed [31:0] carry_in;
  logic signed [32:0] c1_x, f1_x;
  logic [31:0]        c1_mag, f1_mag;
  logic [63:0]        pc_full;

  // Stage B2: carry times factor.
  logic               b2_valid_q, b2_last_q;
  logic [AW-1:0]      b2_idx_q;
  logic [PC_W-1:0]    pc_mag_q;
  logic               pc_neg_q;
  logic signed [GT_W-1:0] b2_gt_q;
  logic signed [65:0] csum;

  // Stage B3: saturated carry.
  logic               b3_valid_q, b3_last_q;
  logic [AW-1:0]      b3_idx_q;
  logic signed [31:0] carry_q;
  logic signed [32:0] c3_x;
  logic [31:0]        c3_mag;
  logic [30:0]        scale;
  logic signed [31:0] decay;
  logic [30:0]        d_mag;
  logic [62:0]        pi_full, ps_full;

  // Stage B4: output products.
  logic               b4_valid_q, b4_last_q;
  logic [AW-1:0]      b4_idx_q;
  logic [PO_W-1:0]    pi_mag_q, ps_mag_q;
  logic               pi_neg_q, ps_neg_q;
  logic signed [31:0] igrad, stored;

  logic               out_valid_q, out_last_q;
  logic [63:0]        out_data_q;

  assign adv        = !out_valid_q || out_ready_i;
  // An item that reads the carry memory waits while an older item of the
  // same neuron has not written its carry back.
  assign hazard     = b0_valid_q && !b0_first_q &&
                      ((b1_valid_q && (b1_idx_q == b0_idx_q)) ||
                       (b2_valid_q && (b2_idx_q == b0_idx_q)) ||
                       (b3_valid_q && (b3_idx_q == b0_idx_q)) ||
                       (b4_valid_q && (b4_idx_q == b0_idx_q)));
  assign front_en_o = adv && !hazard;

  if (NEURONS >= (1 << IDX_W)) begin : g_idx_wide
    assign idx_red = AW'(item_i.idx);
  end else begin : g_idx_mod
    logic [30:0]        qprod;
    logic [IDX_W-1:0]   qv;
    logic [26:0]        rr;
    assign qprod   = 31'(item_i.idx) * 31'(RECIP);
    assign qv      = qprod[29:20];
    assign rr      = 27'(item_i.idx) - 27'(qv) * 27'(NEURONS);
    assign idx_red = AW'(rr);
  end

  always_comb begin
    if (cfg_i.hard_reset) begin
      a_op = $signed({cfg_i.reset_level[31], cfg_i.reset_level})
           - $signed({item_i.membrane[31], item_i.membrane});
    end else begin
      a_op = $signed({cfg_i.threshold[31], cfg_i.threshold});
    end
    a_neg   = a_op[32];
    a_mag   = a_neg ? 33'(-a_op) : 33'(a_op);
    pf_full = 63'(a_mag) * 63'(sg_i);
    gs_x    = $signed({item_i.spike_grad[31], item_i.spike_grad});
    g_mag   = gs_x[32] ? 32'(-gs_x) : 32'(gs_x);
    pg_full = 62'(g_mag) * 62'(sg_i);
  end

  always_comb begin
    // Hard reset adds the product, soft reset subtracts threshold times sg.
    term    = apply_sign(64'(pf_mag_q), pf_neg_q ^ !cfg_i.hard_reset);
    base    = (cfg_i.hard_reset && p1_spike_q) ? 66'sd0 : (66'sd1 <<< FRAC_BITS);
    f_d     = sat32(base + (cfg_i.detach_reset ? 66'sd0 : term));
    gt_full = apply_sign(64'(pg_mag_q), pg_neg_q);
  end

  always_comb begin
    carry_in = b1_first_q ? b1_fvg_q : $signed(rd_q);
    c1_x     = $signed({carry_in[31], carry_in});
    f1_x     = $signed({b1_f_q[31], b1_f_q});
    c1_mag   = c1_x[32] ? 32'(-c1_x) : 32'(c1_x);
    f1_mag   = f1_x[32] ? 32'(-f1_x) : 32'(f1_x);
    pc_full  = 64'(c1_mag) * 64'(f1_mag);
  end

  assign csum = apply_sign(64'(pc_mag_q), pc_neg_q) + 66'(b2_gt_q);

  always_comb begin
    c3_x    = $signed({carry_q[31], carry_q});
    c3_mag  = c3_x[32] ? 32'(-c3_x) : 32'(c3_x);
    scale   = cfg_i.decay_input ? 31'(cfg_i.rtau) : (31'(1) << FRAC_BITS);
    decay   = $signed(32'(1) << FRAC_BITS) - $signed(32'(cfg_i.rtau));
    d_mag   = decay[31] ? 31'(-decay) : 31'(decay);
    pi_full = 63'(c3_mag) * 63'(scale);
    ps_full = 63'(c3_mag) * 63'(d_mag);
  end

  assign igrad  = sat32(apply_sign(64'(pi_mag_q), pi_neg_q));
  assign stored = sat32(apply_sign(64'(ps_mag_q), ps_neg_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      b0_valid_q  <= 1'b0;
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      b3_valid_q  <= 1'b0;
      b4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (front_en_o) begin
        p1_valid_q <= valid_i;
        b0_valid_q <= p1_valid_q;
      end
      if (adv) begin
        b1_valid_q  <= b0_valid_q && !hazard;
        b2_valid_q  <= b1_valid_q;
        b3_valid_q  <= b2_valid_q;
        b4_valid_q  <= b3_valid_q;
        out_valid_q <= b4_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (front_en_o) begin
      p1_idx_q   <= idx_red;
      p1_spike_q <= item_i.spike;
      p1_first_q <= item_i.first;
      p1_last_q  <= item_i.last;
      p1_fvg_q   <= item_i.fvg;
      pf_mag_q   <= pf_full[62:FRAC_BITS];
      pf_neg_q   <= a_neg;
      pg_mag_q   <= pg_full[61:FRAC_BITS];
      pg_neg_q   <= gs_x[32];
      b0_idx_q   <= p1_idx_q;
      b0_first_q <= p1_first_q;
      b0_last_q  <= p1_last_q;
      b0_fvg_q   <= p1_fvg_q;
      b0_f_q     <= f_d;
      b0_gt_q    <= gt_full[GT_W-1:0];
    end
    if (adv) begin
      rd_q       <= mem_q[b0_idx_q];
      b1_idx_q   <= b0_idx_q;
      b1_first_q <= b0_first_q;
      b1_last_q  <= b0_last_q;
      b1_fvg_q   <= b0_fvg_q;
      b1_f_q     <= b0_f_q;
      b1_gt_q    <= b0_gt_q;
      b2_idx_q   <= b1_idx_q;
      b2_last_q  <= b1_last_q;
      pc_mag_q   <= pc_full[62:FRAC_BITS];
      pc_neg_q   <= c1_x[32] ^ f1_x[32];
      b2_gt_q    <= b1_gt_q;
      b3_idx_q   <= b2_idx_q;
      b3_last_q  <= b2_last_q;
      carry_q    <= sat32(csum);
      b4_idx_q   <= b3_idx_q;
      b4_last_q  <= b3_last_q;
      pi_mag_q   <= pi_full[62:FRAC_BITS];
      pi_neg_q   <= c3_x[32];
      ps_mag_q   <= ps_full[62:FRAC_BITS];
      ps_neg_q   <= c3_x[32] ^ decay[31];
      out_last_q <= b4_last_q;
      out_data_q <= {(b4_last_q ? stored : 32'sd0), igrad};
      if (b4_valid_q) begin
        mem_q[b4_idx_q] <= stored;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  a_hazard_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && hazard |=> !b1_valid_q)
    else $error("dependent item entered the carry read stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(b4_valid_q) && $stable(b1_valid_q))
    else $error("carry stages moved during an output stall");

  a_initial_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> out_data_q[63:32] == 32'd0)
    else $error("initial voltage gradient set on a step that is not the last");

endmodule
`default_nettype wire

// ===== rtl/core/lif_neuron_backward_atan_surrogate.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LIF neuron backward pass with arctan surrogate
// Backward pass through time of leaky integrate-and-fire neurons.
// ----------------------------------------------------------------------------
// Items stream in on the s_axis channel, one time step of one neuron per
// transfer, each neuron in reverse time order. s_axis_tuser marks the first
// (latest) step, which loads the final voltage gradient; s_axis_tlast marks
// time step zero. Every item yields one m_axis transfer with the input
// gradient; on the last step the upper word carries the initial voltage
// gradient and m_axis_tlast is set.
// Four stages form the surrogate denominator, a 30-stage divider produces one
// quotient bit per stage, and seven stages handle the reset factor, the carry
// memory and the output scaling.
// One item is taken per cycle when nothing stalls. An item that reads the
// carry of a neuron whose previous step is still within the four carry stages
// waits until that write is done; this is the loop through the carry memory.
// Reset restores the register defaults and empties the pipeline; the carry
// memory is not cleared, so each neuron must begin with a first step.
// When the receiver stalls, the whole pipeline holds and s_axis_tready drops.
// Write configuration via cfg_we_i only while the block is idle (unchecked).
// ----------------------------------------------------------------------------
module lif_neuron_backward_atan_surrogate #(
  parameter int unsigned NEURONS   = 1024,
  parameter int unsigned FRAC_BITS = 24
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lnb_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [lnb_pkg::DATA_W-1:0]      cfg_wdata_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // neuron_index[9:0], membrane[41:10], spike_out[42], spike_grad[74:43],
  // final_voltage_grad[106:75], zero fill[111:107]
  input  wire logic [111:0]                    s_axis_tdata,
  // first_step[0]
  input  wire logic [0:0]                      s_axis_tuser,
  input  wire logic                            s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // input_grad[31:0], initial_voltage_grad[63:32]
  output logic [63:0]                          m_axis_tdata,
  output logic                                 m_axis_tlast
);
  import lnb_pkg::*;

  localparam int unsigned DEN_W = den_width(FRAC_BITS);

  cfg_t  cfg_q;
  item_t in_item;
  logic  front_en;

  logic             fr_valid;
  item_t            fr_item;
  logic [DEN_W-1:0] fr_den;

  logic              dv_valid;
  item_t             dv_item;
  logic [QUOT_W-1:0] dv_sg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold    <= 32'sd16777216;
      cfg_q.reset_level  <= 32'sd0;
      cfg_q.alpha        <= 31'd33554432;
      cfg_q.rtau         <= 25'd8388608;
      cfg_q.decay_input  <= 1'b1;
      cfg_q.hard_reset   <= 1'b1;
      cfg_q.detach_reset <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_THRESHOLD:    cfg_q.threshold    <= $signed(cfg_wdata_i);
        CFG_RESET_LEVEL:  cfg_q.reset_level  <= $signed(cfg_wdata_i);
        CFG_ALPHA:        cfg_q.alpha        <= cfg_wdata_i[ALPHA_W-1:0];
        CFG_RTAU:         cfg_q.rtau         <= cfg_wdata_i[RTAU_W-1:0];
        CFG_DECAY_INPUT:  cfg_q.decay_input  <= cfg_wdata_i[0];
        CFG_HARD_RESET:   cfg_q.hard_reset   <= cfg_wdata_i[0];
        CFG_DETACH_RESET: cfg_q.detach_reset <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.idx        = s_axis_tdata[9:0];
    in_item.membrane   = $signed(s_axis_tdata[41:10]);
    in_item.spike      = s_axis_tdata[42];
    in_item.spike_grad = $signed(s_axis_tdata[74:43]);
    in_item.fvg        = $signed(s_axis_tdata[106:75]);
    in_item.first      = s_axis_tuser[0];
    in_item.last       = s_axis_tlast;
  end

  assign s_axis_tready = front_en;

  lnb_front #(
    .FRAC_BITS(FRAC_BITS),
    .DEN_W    (DEN_W)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (front_en),
    .cfg_i  (cfg_q),
    .valid_i(s_axis_tvalid),
    .item_i (in_item),
    .valid_o(fr_valid),
    .item_o (fr_item),
    .den_o  (fr_den)
  );

  lnb_divider #(
    .FRAC_BITS(FRAC_BITS),
    .DEN_W    (DEN_W)
  ) u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (front_en),
    .cfg_i  (cfg_q),
    .valid_i(fr_valid),
    .item_i (fr_item),
    .den_i  (fr_den),
    .valid_o(dv_valid),
    .item_o (dv_item),
    .sg_o   (dv_sg)
  );

  lnb_backend #(
    .NEURONS  (NEURONS),
    .FRAC_BITS(FRAC_BITS)
  ) u_backend (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .valid_i    (dv_valid),
    .item_i     (dv_item),
    .sg_i       (dv_sg),
    .front_en_o (front_en),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ===== bench/lif_neuron_backward_atan_surrogate_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIF backward pass bench
// Streams time steps of many interleaved neurons through the block under
// several register settings. A bit-accurate gradient predictor follows every
// accepted transfer, and each output transfer is compared field by field.
// ----------------------------------------------------------------------------

class grad_checker;
  typedef struct {
    logic signed [31:0] input_grad;
    logic signed [31:0] init_grad;
    logic               init_valid;
  } grad_t;

  grad_t       pending_grads[$];
  longint      carry_mem[1024];
  longint      thr;
  longint      rst_lvl;
  longint      alpha;
  longint      rtau;
  bit          decay_in;
  bit          hard;
  bit          detach;
  int          errors;
  int          n_items;
  int          n_results;
  int          n_initial;

  function new();
    thr = 16777216;
    rst_lvl = 0;
    alpha = 33554432;
    rtau = 8388608;
    decay_in = 1;
    hard = 1;
    detach = 0;
  endfunction

  function void set_reg(lnb_pkg::cfg_reg_e r, logic [31:0] v);
    case (r)
      lnb_pkg::CFG_THRESHOLD:    thr = longint'($signed(v));
      lnb_pkg::CFG_RESET_LEVEL:  rst_lvl = longint'($signed(v));
      lnb_pkg::CFG_ALPHA:        alpha = longint'(v[30:0]);
      lnb_pkg::CFG_RTAU:         rtau = longint'(v[24:0]);
      lnb_pkg::CFG_DECAY_INPUT:  decay_in = v[0];
      lnb_pkg::CFG_HARD_RESET:   hard = v[0];
      lnb_pkg::CFG_DETACH_RESET: detach = v[0];
      default: ;
    endcase
  endfunction

  function logic [63:0] magn(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Product shifted down by the fraction width, truncated toward zero.
  function longint qmul(longint a, longint b);
    logic [127:0] p;
    p = ({64'd0, magn(a)} * {64'd0, magn(b)}) >> 24;
    return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function longint atan_slope(longint h);
    logic [63:0]  pscale;
    logic [63:0]  span;
    logic [63:0]  x;
    logic [127:0] sq;
    logic [127:0] num;
    pscale = (64'(alpha) * 64'(lnb_pkg::HALFPI_Q30)) >> 30;
    span = magn(h - thr);
    // The scaled distance fits in 64 bits before the shift.
    x = (span * pscale) >> 24;
    sq = ({64'd0, x} * {64'd0, x}) >> 24;
    if (sq >= (128'd1 << 62)) sq = 128'd1 << 62;
    num = 128'(alpha) << 23;
    return longint'(num / (sq + (128'd1 << 24)));
  endfunction

  function void note(lnb_pkg::item_t it);
    longint carry;
    longint sg;
    longint f;
    longint scale;
    longint stored;
    grad_t  g;
    carry = it.first ? longint'(it.fvg) : carry_mem[it.idx];
    sg = atan_slope(longint'(it.membrane));
    if (hard) begin
      f = it.spike ? 0 : 64'sd16777216;
      if (!detach) f += qmul(rst_lvl - longint'(it.membrane), sg);
    end else if (detach) begin
      f = 64'sd16777216;
    end else begin
      f = 64'sd16777216 - qmul(thr, sg);
    end
    f = clip32(f);
    carry = clip32(qmul(carry, f) + qmul(longint'(it.spike_grad), sg));
    scale = decay_in ? rtau : 64'sd16777216;
    stored = clip32(qmul(carry, 64'sd16777216 - rtau));
    carry_mem[it.idx] = stored;
    g.input_grad = 32'(clip32(qmul(carry, scale)));
    g.init_grad = it.last ? 32'(stored) : 32'd0;
    g.init_valid = it.last;
    pending_grads.push_back(g);
    n_items++;
  endfunction

  function void check(logic [63:0] data, logic last);
    grad_t g;
    n_results++;
    if (last) n_initial++;
    if (pending_grads.size() == 0) begin
      $error("result transfer with no prediction waiting: %h", data);
      errors++;
      return;
    end
    g = pending_grads.pop_front();
    if (data[31:0] !== g.input_grad) begin
      $error("input_grad expected %h actual %h", g.input_grad, data[31:0]);
      errors++;
    end
    if (data[63:32] !== g.init_grad) begin
      $error("initial_voltage_grad expected %h actual %h", g.init_grad, data[63:32]);
      errors++;
    end
    if (last !== g.init_valid) begin
      $error("initial_valid expected %b actual %b", g.init_valid, last);
      errors++;
    end
  endfunction
endclass

module lif_neuron_backward_atan_surrogate_test;
  import lnb_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_addr_i = '0;
  logic [31:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tlast;

  grad_checker  chk = new();
  bit           calm = 1'b0;
  bit           started[1024];
  int           steps_left[1024];
  int           phases_run = 0;

  lif_neuron_backward_atan_surrogate dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #(4 * 500000);
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) chk.check(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= calm || ($urandom_range(99) >= 22);
  end

  // Entered and left right after a rising edge.
  task automatic push(item_t it);
    if (!calm && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, it.fvg, it.spike_grad, it.spike, it.membrane, it.idx};
    s_axis_tuser <= it.first;
    s_axis_tlast <= it.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    chk.note(it);
    started[it.idx] = 1'b1;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (chk.pending_grads.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= r;
    cfg_wdata_i <= v;
    chk.set_reg(r, v);
    @(posedge clk_i);
  endtask

  task automatic configure(logic [31:0] thr, logic [31:0] rl, logic [31:0] al,
                           logic [31:0] rt, bit di, bit hr, bit dr);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_RESET_LEVEL, rl);
    write_reg(CFG_ALPHA, al);
    write_reg(CFG_RTAU, rt);
    write_reg(CFG_DECAY_INPUT, 32'(di));
    write_reg(CFG_HARD_RESET, 32'(hr));
    write_reg(CFG_DETACH_RESET, 32'(dr));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] near_thr();
    logic [31:0] off;
    off = $urandom_range(3) == 0 ? $urandom() : 32'($signed($urandom_range(0, 1 << 26)) -
          (1 << 25));
    return 32'(chk.thr) + off;
  endfunction

  // One step of a well-formed neuron sequence, or noise now and then.
  task automatic random_step();
    item_t it;
    int    n;
    n = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(15);
    it.idx = n[9:0];
    it.spike = $urandom_range(1);
    it.spike_grad = $urandom_range(3) == 0 ? $urandom() : 32'($signed($urandom_range(0,
                    1 << 25)) - (1 << 24));
    it.fvg = $urandom();
    it.membrane = near_thr();
    if ($urandom_range(9) == 0) begin
      it.membrane = $urandom();
      it.first = !started[n] || $urandom_range(1);
      it.last = $urandom_range(1);
      steps_left[n] = 0;
    end else if (steps_left[n] == 0) begin
      steps_left[n] = $urandom_range(1, 8);
      it.first = 1'b1;
      it.last = (steps_left[n] == 1);
      steps_left[n]--;
    end else begin
      it.first = 1'b0;
      it.last = (steps_left[n] == 1);
      steps_left[n]--;
    end
    push(it);
  endtask

  task automatic directed();
    item_t it;
    logic [31:0] edges[6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                              32'h0100_0000, 32'h00FF_FFFF};
    for (int k = 0; k < 24; k++) begin
      it.idx = (k % 3 == 0) ? 10'd1023 : (k % 3 == 1) ? 10'd0 : 10'(k);
      it.membrane = edges[k % 6];
      it.spike = k[0];
      it.spike_grad = edges[(k + 1) % 6];
      it.fvg = edges[(k + 2) % 6];
      it.first = (k < 3) || (k % 5 == 0) || !started[it.idx];
      it.last = (k % 4 == 3) || (k == 23);
      push(it);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: configure(32'h0100_0000, 32'h0, 32'h0200_0000, 32'h0080_0000, 1, 1, 0);
        1: configure(32'h0080_0000, 32'hFF00_0000, 32'h0400_0000, 32'h0040_0000, 1, 1, 1);
        2: configure(32'hFF80_0000, 32'h0, 32'h0100_0000, 32'h0100_0000, 0, 0, 0);
        3: configure(32'h0200_0000, 32'h0100_0000, 32'h0080_0000, 32'h0020_0000, 1, 0, 1);
        4: configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 0, 1, 0);
        5: configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h01FF_FFFF, 1, 0, 0);
        default: configure($urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom_range(1), $urandom_range(1), $urandom_range(1));
      endcase
      calm = (p == 3);
      for (int k = 0; k < 160; k++) random_step();
      phases_run++;
    end
    calm = 1'b0;
    drain();
    $display("Covered %0d items in %0d register settings after the directed steps.",
             chk.n_items, phases_run);
    $display("Checked %0d results, %0d of them with an initial voltage gradient.",
             chk.n_results, chk.n_initial);
    if (chk.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== lif_neuron_backward_atan_surrogate.f =====
rtl/core/lnb_pkg.sv
rtl/core/lnb_front.sv
rtl/core/lnb_divider.sv
rtl/core/lnb_backend.sv
rtl/core/lif_neuron_backward_atan_surrogate.sv
bench/lif_neuron_backward_atan_surrogate_test.sv
